### rtl/core/hwd_pkg.sv
// Shared types, constants and helpers for the Haar wavelet denoise core.
// Used by hwd_ctrl, hwd_dp and haar_wavelet_denoise_core; no dependencies.
`timescale 1ns / 1ps
package hwd_pkg;

  localparam int unsigned AddrW   = 6;
  localparam int unsigned Depth   = 64;
  localparam int unsigned SampleW = 16;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned ThrW    = 31;
  localparam int unsigned ProdW   = 51;
  localparam logic signed [17:0] HaarK = 18'sd92682;

  localparam logic [1:0] ModeFwd = 2'd0;
  localparam logic [1:0] ModeInv = 2'd1;
  localparam logic [1:0] ModeDen = 2'd2;

  localparam logic [1:0] RegMode   = 2'd0;
  localparam logic [1:0] RegLength = 2'd1;
  localparam logic [1:0] RegThresh = 2'd2;

  typedef enum logic [1:0] {
    CW_LOAD,
    CW_COPY,
    CW_SHRINK
  } cw_sel_e;

  typedef struct packed {
    logic             rd_en;
    logic [AddrW-1:0] ra0;
    logic [AddrW-1:0] ra1;
    logic             sc_rd_en;
    logic [AddrW-1:0] sc_ra;
    logic             mul_en;
    logic             mul_diff;
    logic             sc_we;
    logic [AddrW-1:0] sc_wa;
    logic             cw_en;
    cw_sel_e          cw_sel;
    logic [AddrW-1:0] cw_wa;
    logic             out_ld;
    logic             out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_sts_t;

  // Clamp the length register to the supported range 1..6.
  function automatic logic [2:0] clamp_lg(input logic [2:0] lg);
    logic [2:0] r;
    r = lg;
    if (lg == 3'd0) r = 3'd1;
    if (lg == 3'd7) r = 3'd6;
    return r;
  endfunction

endpackage

### rtl/core/hwd_dp.sv
// Datapath: coefficient and scratch memories, Haar butterfly, shrink, output register.
// Depends on hwd_pkg; driven by hwd_ctrl commands.
`timescale 1ns / 1ps
module hwd_dp import hwd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dp_cmd_t                   cmd_i,
  output dp_sts_t                   sts_o,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic [ThrW-1:0]           thresh_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [ValueW-1:0]  out_value_o,
  output logic                      out_last_o
);

  logic signed [ValueW-1:0] coeff_mem [Depth];
  logic signed [ValueW-1:0] scr_mem   [Depth];
  logic signed [ValueW-1:0] a_q, b_q, sc_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [32:0]       ab;
  logic signed [ProdW-1:0]  pr_rnd, pr_sh;
  logic signed [ValueW-1:0] y_sat, shr, cw_data;
  logic signed [32:0]       xe, te;
  logic                     out_valid_q;
  logic signed [ValueW-1:0] out_value_q;
  logic                     out_last_q;

  assign ab = cmd_i.mul_diff ? (33'(a_q) - 33'(b_q)) : (33'(a_q) + 33'(b_q));

  // round half up, drop 17 fraction bits, saturate to Q15.16
  always_comb begin
    pr_rnd = prod_q + (ProdW'(1) <<< 16);
    pr_sh  = pr_rnd >>> 17;
    if (pr_sh > ProdW'(32'sh7fffffff)) y_sat = 32'sh7fffffff;
    else if (pr_sh < -(ProdW'(64'sh80000000))) y_sat = 32'sh80000000;
    else y_sat = pr_sh[ValueW-1:0];
  end

  always_comb begin
    xe = 33'(a_q);
    te = {2'b00, thresh_i};
    if (xe > te) shr = 32'(xe - te);
    else if (xe < -te) shr = 32'(xe + te);
    else shr = '0;
  end

  always_comb begin
    case (cmd_i.cw_sel)
      CW_LOAD:   cw_data = {{12{sample_i[SampleW-1]}}, sample_i, 4'b0000};
      CW_COPY:   cw_data = sc_q;
      CW_SHRINK: cw_data = shr;
      default:   cw_data = sc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cw_en) coeff_mem[cmd_i.cw_wa] <= cw_data;
    if (cmd_i.rd_en) begin
      a_q <= coeff_mem[cmd_i.ra0];
      b_q <= coeff_mem[cmd_i.ra1];
    end
    if (cmd_i.sc_we) scr_mem[cmd_i.sc_wa] <= y_sat;
    if (cmd_i.sc_rd_en) sc_q <= scr_mem[cmd_i.sc_ra];
    if (cmd_i.mul_en) prod_q <= ab * HaarK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_value_q <= a_q;
      out_last_q  <= cmd_i.out_last;
    end
  end

  assign sts_o.out_busy = out_valid_q;
  assign out_valid_o    = out_valid_q;
  assign out_value_o    = out_value_q;
  assign out_last_o     = out_last_q;

endmodule

### rtl/core/hwd_ctrl.sv
// Sequencer for load, analysis, shrink, synthesis and emission of one block.
// Depends on hwd_pkg; commands hwd_dp.
`timescale 1ns / 1ps
module hwd_ctrl import hwd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] mode_i,
  input  logic [2:0] lg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output dp_cmd_t    cmd_o,
  input  dp_sts_t    sts_i
);

  typedef enum logic [3:0] {
    S_LOAD, S_BF_RD, S_BF_MS, S_BF_WS, S_BF_WD, S_CP_RD, S_CP_WR,
    S_TH_RD, S_TH_WR, S_OUT_RD, S_OUT_WR
  } state_e;

  state_e     state_q, state_d;
  logic [6:0] lc_q, lc_d, cnt_q, cnt_d;
  logic [2:0] hl_q, hl_d;
  logic       syn_q, syn_d;
  logic [2:0] lg;
  logic [6:0] n, nm1, cp_last, lc_inc;
  logic [AddrW-1:0] i6, h6;

  assign lg      = clamp_lg(lg_i);
  assign n       = 7'd1 << lg;
  assign nm1     = n - 7'd1;
  assign cp_last = (7'd1 << (hl_q + 3'd1)) - 7'd1;
  assign lc_inc  = lc_q + 7'd1;
  assign i6      = cnt_q[AddrW-1:0];
  assign h6      = AddrW'(6'd1 << hl_q);
  assign in_ready_o = (state_q == S_LOAD);

  always_comb begin
    state_d = state_q;
    lc_d    = lc_q;
    cnt_d   = cnt_q;
    hl_d    = hl_q;
    syn_d   = syn_q;
    cmd_o   = '0;
    cmd_o.cw_sel = CW_LOAD;
    cmd_o.ra0 = syn_q ? i6 : {i6[4:0], 1'b0};
    cmd_o.ra1 = syn_q ? (h6 + i6) : {i6[4:0], 1'b1};
    unique case (state_q)
      S_LOAD: begin
        cmd_o.cw_wa = lc_q[AddrW-1:0];
        if (in_valid_i) begin
          cmd_o.cw_en = 1'b1;
          lc_d = lc_inc;
          if (lc_inc >= n) begin
            lc_d  = '0;
            cnt_d = '0;
            state_d = S_BF_RD;
            if (mode_i == ModeInv) begin
              syn_d = 1'b1;
              hl_d  = '0;
            end else begin
              syn_d = 1'b0;
              hl_d  = lg - 3'd1;
            end
          end
        end
      end
      S_BF_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d = S_BF_MS;
      end
      S_BF_MS: begin
        cmd_o.mul_en = 1'b1;
        state_d = S_BF_WS;
      end
      S_BF_WS: begin
        cmd_o.sc_we    = 1'b1;
        cmd_o.sc_wa    = syn_q ? {i6[4:0], 1'b0} : i6;
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_diff = 1'b1;
        state_d = S_BF_WD;
      end
      S_BF_WD: begin
        cmd_o.sc_we = 1'b1;
        cmd_o.sc_wa = syn_q ? {i6[4:0], 1'b1} : (h6 + i6);
        if (i6 == h6 - AddrW'(1)) begin
          cnt_d = '0;
          state_d = S_CP_RD;
        end else begin
          cnt_d = cnt_q + 7'd1;
          state_d = S_BF_RD;
        end
      end
      S_CP_RD: begin
        cmd_o.sc_rd_en = 1'b1;
        cmd_o.sc_ra    = i6;
        state_d = S_CP_WR;
      end
      S_CP_WR: begin
        cmd_o.cw_en  = 1'b1;
        cmd_o.cw_sel = CW_COPY;
        cmd_o.cw_wa  = i6;
        if (cnt_q != cp_last) begin
          cnt_d = cnt_q + 7'd1;
          state_d = S_CP_RD;
        end else if (syn_q) begin
          cnt_d = '0;
          if (hl_q == lg - 3'd1) begin
            state_d = S_OUT_RD;
          end else begin
            hl_d = hl_q + 3'd1;
            state_d = S_BF_RD;
          end
        end else if (hl_q != 3'd0) begin
          cnt_d = '0;
          hl_d  = hl_q - 3'd1;
          state_d = S_BF_RD;
        end else if (mode_i == ModeFwd) begin
          cnt_d = '0;
          state_d = S_OUT_RD;
        end else if (lg == 3'd1) begin
          // two-sample block: no detail below the coarsest one
          cnt_d = '0;
          syn_d = 1'b1;
          state_d = S_BF_RD;
        end else begin
          cnt_d = 7'd2;
          state_d = S_TH_RD;
        end
      end
      S_TH_RD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.ra0   = i6;
        state_d = S_TH_WR;
      end
      S_TH_WR: begin
        cmd_o.cw_en  = 1'b1;
        cmd_o.cw_sel = CW_SHRINK;
        cmd_o.cw_wa  = i6;
        if (cnt_q == nm1) begin
          cnt_d = '0;
          hl_d  = '0;
          syn_d = 1'b1;
          state_d = S_BF_RD;
        end else begin
          cnt_d = cnt_q + 7'd1;
          state_d = S_TH_RD;
        end
      end
      S_OUT_RD: begin
        cmd_o.ra0 = i6;
        if (!sts_i.out_busy) begin
          cmd_o.rd_en = 1'b1;
          state_d = S_OUT_WR;
        end
      end
      S_OUT_WR: begin
        cmd_o.out_ld   = 1'b1;
        cmd_o.out_last = (cnt_q == nm1);
        if (cnt_q == nm1) begin
          state_d = S_LOAD;
        end else begin
          cnt_d = cnt_q + 7'd1;
          state_d = S_OUT_RD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      lc_q    <= '0;
      cnt_q   <= '0;
      hl_q    <= '0;
      syn_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      lc_q    <= lc_d;
      cnt_q   <= cnt_d;
      hl_q    <= hl_d;
      syn_q   <= syn_d;
    end
  end

  a_lc_range: assert property (@(posedge clk_i) disable iff (!rst_ni) lc_q <= 7'd64)
    else $error("load count beyond block store");
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_ld |-> !sts_i.out_busy)
    else $error("output register overwritten");
  a_last_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_ld && cmd_o.out_last) |=> state_q == S_LOAD)
    else $error("no return to loading after last beat");

endmodule

### rtl/core/haar_wavelet_denoise_core.sv
// Top level of the multilevel Haar wavelet denoise core: config registers and wiring.
// Depends on hwd_pkg, hwd_ctrl and hwd_dp.
`timescale 1ns / 1ps
// Collects a block of 2^length_log2 Q3.12 samples (2 to 64), widens each to Q15.16,
// and when the last sample of the block arrives runs the selected job: full
// multilevel Haar analysis (mode 0), synthesis of loaded coefficients (mode 1),
// or denoise (other modes: analysis, soft threshold of every detail except the
// coarsest one, then synthesis). The whole block is then emitted, tlast on its
// final beat. Each butterfly multiplies a sum or difference by 1/sqrt2 in Q1.17,
// rounds half up and saturates to 32 bits. Timing: one beat per cycle while
// loading; after the last sample, each level of h butterflies runs on the
// single multiplier, then 2h scratch entries are copied back to coefficient
// memory; emission waits for each beat to be taken before reading the next.
// Input is taken only during loading; the next block may start loading while
// the final result still waits downstream.
module haar_wavelet_denoise_core import hwd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [SampleW-1:0]        s_axis_tdata_i,   // [15:0] sample
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [ValueW-1:0]         m_axis_tdata_o,   // [31:0] value
  output logic                      m_axis_tlast_o,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [ThrW-1:0]           cfg_data_i
);

  logic [1:0]      mode_q;
  logic [2:0]      lg_q;
  logic [ThrW-1:0] thr_q;
  dp_cmd_t         cmd;
  dp_sts_t         sts;
  logic signed [ValueW-1:0] out_value;

  // Hold configuration; a write to an unused index is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeDen;
      lg_q   <= 3'd6;
      thr_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMode:   mode_q <= cfg_data_i[1:0];
        RegLength: lg_q   <= cfg_data_i[2:0];
        RegThresh: thr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hwd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mode_i     (mode_q),
    .lg_i       (lg_q),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  hwd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sample_i    ($signed(s_axis_tdata_i)),
    .thresh_i    (thr_q),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_value_o (out_value),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = out_value;

endmodule
